/* sv/vdp_pkg.sv */
// ============================================================================
// vdp_pkg: shared types and constants for the video display processor port
// Holds the command and result structures, the command codes and the fixed
// widths and reset values used by the front end, the back end and the queues.
// ============================================================================
package vdp_pkg;

    localparam int ADDR_W         = 14;
    localparam int FRAME_W        = 24;
    localparam int VRAM_DEPTH_DEF = 16384;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [FRAME_W-1:0] DEFAULT_FRAME_PERIOD = FRAME_W'(1000000 / 60);

    // Bit positions inside the status byte, register 1 and the second control byte.
    localparam int STATUS_IRQ_BIT = 7;
    localparam int R1_IRQ_EN_BIT  = 5;
    localparam int CTRL_REG_BIT   = 7;
    localparam int CTRL_WRITE_BIT = 6;

    // Bus request codes and port selects.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic       PORT_DATA = 1'b0;

    localparam logic [2:0] IRQ_EN_REG = 3'd1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DATA_RD,
        OP_STAT_RD,
        OP_DATA_WR,
        OP_CTRL_WR,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] wdata;
    } t_cmd;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
    } t_res;

endpackage

/* sv/vdp_fifo.sv */
// ============================================================================
// vdp_fifo: small first-in first-out queue
// Register-based queue with a combinational head, used between the front end
// and the back end and again in front of the result ports.
// ============================================================================
module vdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vdp_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/vdp_front.sv */
// ============================================================================
// vdp_front: request classifier
// Turns a bus request into one command for the back end and holds off new
// requests while the command queue is full or video memory is being cleared.
// ============================================================================
module vdp_front (
    input  logic              i_push,
    input  logic [1:0]        i_req_type,
    input  logic              i_port,
    input  logic [7:0]        i_wdata,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_full,
    output logic              o_q_push,
    output vdp_pkg::t_cmd     o_cmd
);

    assign o_full   = i_q_full || i_clearing;
    assign o_q_push = i_push && !o_full;

    always_comb begin
        o_cmd.wdata = i_wdata;
        unique case (i_req_type)
            vdp_pkg::REQ_READ: begin
                o_cmd.op = (i_port == vdp_pkg::PORT_DATA) ? vdp_pkg::OP_DATA_RD
                                                          : vdp_pkg::OP_STAT_RD;
            end
            vdp_pkg::REQ_WRITE: begin
                o_cmd.op = (i_port == vdp_pkg::PORT_DATA) ? vdp_pkg::OP_DATA_WR
                                                          : vdp_pkg::OP_CTRL_WR;
            end
            vdp_pkg::REQ_TICK: begin
                o_cmd.op = vdp_pkg::OP_TICK;
            end
            default: begin
                // The unused request code still yields a result, with no effect.
                o_cmd.op = vdp_pkg::OP_NOP;
            end
        endcase
    end

endmodule

/* sv/vdp_back.sv */
// ============================================================================
// vdp_back: command executor
// Holds the port state, video memory and frame timer, executes one command a cycle
// when one waits, results have room and no clear runs; clears video memory after reset.
// ============================================================================
module vdp_back #(
    parameter int VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vdp_pkg::FRAME_W-1:0]  i_cfg_wdata,
    input  vdp_pkg::t_cmd                i_cmd,
    input  logic                         i_cmd_empty,
    output logic                         o_cmd_pop,
    input  logic                         i_res_full,
    output logic                         o_res_push,
    output vdp_pkg::t_res                o_res,
    output logic                         o_clearing
);

    localparam int ADDR_W    = vdp_pkg::ADDR_W;
    localparam int FRAME_W   = vdp_pkg::FRAME_W;
    localparam int IDX_W     = $clog2(VRAM_DEPTH);
    localparam int MOD_STEPS = ((1 << ADDR_W) + VRAM_DEPTH - 1) / VRAM_DEPTH - 1;
    localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W + 1)'(VRAM_DEPTH);

    // Smaller memories mirror across the 14-bit address space.
    function automatic logic [IDX_W-1:0] mem_idx(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] v;
        v = {1'b0, a};
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (v >= DEPTH_V) begin
                v = v - DEPTH_V;
            end
        end
        return v[IDX_W-1:0];
    endfunction

    logic [7:0]         r_vram [VRAM_DEPTH];
    logic [7:0]         r_mem_q;

    logic               r_clearing;
    logic [IDX_W-1:0]   r_clr_idx;

    logic [FRAME_W-1:0] r_frame_period;
    logic [FRAME_W-1:0] r_tick,     n_tick;
    logic [7:0]         r_status,   n_status;
    logic [ADDR_W-1:0]  r_addr,     n_addr;
    logic [7:0]         r_latch,    n_latch;
    logic               r_first,    n_first;
    logic [7:0]         r_ra,       n_ra;
    logic               r_ra_mem,   n_ra_mem;
    logic               r_irq_en,   n_irq_en;

    logic               go;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [7:0]         ra_eff;
    logic [ADDR_W-1:0]  set_addr;
    logic [FRAME_W-1:0] tick_inc;

    assign go         = !i_cmd_empty && !i_res_full && !r_clearing;
    assign o_cmd_pop  = go;
    assign o_res_push = go;
    assign o_clearing = r_clearing;

    // After a memory fetch the read-ahead byte lives in the memory output register.
    assign ra_eff   = r_ra_mem ? r_mem_q : r_ra;
    assign set_addr = {i_cmd.wdata[5:0], r_latch};
    assign tick_inc = r_tick + FRAME_W'(1);

    always_comb begin
        n_tick      = r_tick;
        n_status    = r_status;
        n_addr      = r_addr;
        n_latch     = r_latch;
        n_first     = r_first;
        n_ra        = r_ra;
        n_ra_mem    = r_ra_mem;
        n_irq_en    = r_irq_en;
        mem_we      = 1'b0;
        mem_waddr   = mem_idx(r_addr);
        mem_wdata   = i_cmd.wdata;
        mem_re      = 1'b0;
        mem_raddr   = mem_idx(r_addr);
        o_res.rdata = 8'd0;

        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = 8'd0;
        end else if (go) begin
            unique case (i_cmd.op)
                vdp_pkg::OP_DATA_RD: begin
                    o_res.rdata = ra_eff;
                    mem_re      = 1'b1;
                    n_ra_mem    = 1'b1;
                    n_addr      = r_addr + ADDR_W'(1);
                    n_first     = 1'b1;
                end
                vdp_pkg::OP_STAT_RD: begin
                    o_res.rdata = r_status;
                    n_status    = 8'd0;
                    n_first     = 1'b1;
                end
                vdp_pkg::OP_DATA_WR: begin
                    mem_we   = 1'b1;
                    n_ra     = i_cmd.wdata;
                    n_ra_mem = 1'b0;
                    n_addr   = r_addr + ADDR_W'(1);
                    n_first  = 1'b1;
                end
                vdp_pkg::OP_CTRL_WR: begin
                    if (r_first) begin
                        n_latch = i_cmd.wdata;
                        n_first = 1'b0;
                    end else begin
                        n_first = 1'b1;
                        if (i_cmd.wdata[vdp_pkg::CTRL_REG_BIT]) begin
                            // Only register 1 matters here; the rest feed the display core.
                            if (i_cmd.wdata[2:0] == vdp_pkg::IRQ_EN_REG) begin
                                n_irq_en = r_latch[vdp_pkg::R1_IRQ_EN_BIT];
                            end
                        end else if (i_cmd.wdata[vdp_pkg::CTRL_WRITE_BIT]) begin
                            n_addr = set_addr;
                        end else begin
                            // Read-mode address set prefetches the addressed byte.
                            mem_re    = 1'b1;
                            mem_raddr = mem_idx(set_addr);
                            n_ra_mem  = 1'b1;
                            n_addr    = set_addr + ADDR_W'(1);
                        end
                    end
                end
                vdp_pkg::OP_TICK: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_frame_period) begin
                        n_tick = '0;
                        if (r_irq_en) begin
                            n_status[vdp_pkg::STATUS_IRQ_BIT] = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_res.irq = n_status[vdp_pkg::STATUS_IRQ_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing     <= 1'b1;
            r_clr_idx      <= '0;
            r_frame_period <= vdp_pkg::DEFAULT_FRAME_PERIOD;
            r_tick         <= '0;
            r_status       <= 8'd0;
            r_addr         <= '0;
            r_latch        <= 8'd0;
            r_first        <= 1'b1;
            r_ra           <= 8'd0;
            r_ra_mem       <= 1'b0;
            r_irq_en       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(VRAM_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_frame_period <= i_cfg_wdata;
            end
            r_tick   <= n_tick;
            r_status <= n_status;
            r_addr   <= n_addr;
            r_latch  <= n_latch;
            r_first  <= n_first;
            r_ra     <= n_ra;
            r_ra_mem <= n_ra_mem;
            r_irq_en <= n_irq_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_vram[mem_raddr];
        end
    end

    a_no_exec_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_cmd_pop && !o_res_push)
        else $error("command executed during video memory clear");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_read_refills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && i_cmd.op == vdp_pkg::OP_DATA_RD |=> r_ra_mem)
        else $error("data read did not refill the read-ahead buffer from memory");

    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && i_cmd.op == vdp_pkg::OP_DATA_WR |=>
            r_addr == $past(r_addr) + ADDR_W'(1) && !r_ra_mem)
        else $error("data write did not advance the address");

endmodule

/* sv/video_display_processor_cpu_port_top.sv */
// ============================================================================
// video_display_processor_cpu_port_top: CPU bus port of the video processor
// Path: a taken request is registered in the command queue, executed from its head,
//   and its result is registered in the result queue, which drives the result ports.
// Throughput: one transaction per cycle unless the command queue is empty, the result
//   queue is full or memory is clearing; reads land in a registered read-ahead output.
// Reset: synchronous, active low; afterwards video memory is cleared one byte a
//   cycle across all VRAM_DEPTH bytes, with full held high until the sweep ends.
// ============================================================================
module video_display_processor_cpu_port_top #(
    parameter int VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: frame period in ticks.
    input  logic                        i_cfg_we,
    input  logic [vdp_pkg::FRAME_W-1:0] i_cfg_wdata,
    // Request side.
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_req_type,
    input  logic                        i_port,
    input  logic [7:0]                  i_wdata,
    // Result side.
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_rdata,
    output logic                        o_irq
);

    // The front end only classifies, so all ordering lives in the queues and
    // in the executor. Every request produces exactly one result transaction.

    vdp_pkg::t_cmd front_cmd;
    vdp_pkg::t_cmd q_cmd;
    vdp_pkg::t_res back_res;
    vdp_pkg::t_res q_res;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          res_push;
    logic          res_full;
    logic          clearing;

    vdp_front u_front (
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_port     (i_port),
        .i_wdata    (i_wdata),
        .i_q_full   (cmd_full),
        .i_clearing (clearing),
        .o_full     (full),
        .o_q_push   (cmd_push),
        .o_cmd      (front_cmd)
    );

    // Command queue: lets the front end keep accepting while the executor waits
    // on a stalled result side.
    vdp_fifo #(
        .WIDTH ($bits(vdp_pkg::t_cmd)),
        .DEPTH (vdp_pkg::FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd),
        .o_empty (cmd_empty)
    );

    vdp_back #(
        .VRAM_DEPTH (VRAM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .o_clearing  (clearing)
    );

    // Result queue: the oldest result is shown while empty is low.
    vdp_fifo #(
        .WIDTH ($bits(vdp_pkg::t_res)),
        .DEPTH (vdp_pkg::FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_rdata = q_res.rdata;
    assign o_irq   = q_res.irq;

endmodule
